// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the button press classifier.
// Holds the configuration struct, register indexes and event codes.
// No dependencies.
`default_nettype none

package bpc_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned IndexWidth = 2;
  localparam int unsigned ElapsedWidth = 16;
  localparam int unsigned EventWidth = 2;

  localparam logic [IndexWidth-1:0] CFG_FILTER_TIME = 2'd0;
  localparam logic [IndexWidth-1:0] CFG_LONG_TIME   = 2'd1;

  localparam logic [CfgWidth-1:0] FILTER_TIME_RESET = 16'd10;
  localparam logic [CfgWidth-1:0] LONG_TIME_RESET   = 16'd500;

  localparam logic [EventWidth-1:0] EV_NONE  = 2'd0;
  localparam logic [EventWidth-1:0] EV_SHORT = 2'd1;
  localparam logic [EventWidth-1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic [CfgWidth-1:0] filter_time;
    logic [CfgWidth-1:0] long_time;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_cfg_regs.sv =====
// Configuration registers of the button press classifier.
// Depends on bpc_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module bpc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bpc_pkg::IndexWidth-1:0] cfg_index_i,
  input  wire logic [bpc_pkg::CfgWidth-1:0]   cfg_data_i,
  output bpc_pkg::cfg_t                       cfg_o
);

  bpc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_time <= bpc_pkg::FILTER_TIME_RESET;
      cfg_q.long_time   <= bpc_pkg::LONG_TIME_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bpc_pkg::CFG_FILTER_TIME: cfg_q.filter_time <= cfg_data_i;
        bpc_pkg::CFG_LONG_TIME:   cfg_q.long_time   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bpc_fsm.sv =====
// Phase state machine and time-in-phase counter of the button press classifier.
// Depends on bpc_pkg for the cfg_t struct and the event codes.
`default_nettype none

module bpc_fsm #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             advance_i,
  input  wire logic                             button_down_i,
  input  wire logic [bpc_pkg::ElapsedWidth-1:0] elapsed_i,
  input  wire bpc_pkg::cfg_t                    cfg_i,
  output logic      [bpc_pkg::EventWidth-1:0]   event_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FILTER = 3'd1,
    PH_HELD   = 3'd2,
    PH_SHORT  = 3'd3,
    PH_LONG   = 3'd4
  } phase_e;

  localparam int unsigned CmpWidth =
    (TIME_WIDTH > bpc_pkg::CfgWidth) ? TIME_WIDTH : bpc_pkg::CfgWidth;

  phase_e phase_q, phase_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;

  logic [CmpWidth:0] time_ext;
  logic [CmpWidth:0] filter_ext;
  logic [CmpWidth:0] long_ext;
  logic [CmpWidth:0] elapsed_ext;
  logic [CmpWidth:0] time_max;
  logic [CmpWidth:0] sum;

  assign time_ext    = {{(CmpWidth + 1 - TIME_WIDTH){1'b0}}, time_q};
  assign filter_ext  = {{(CmpWidth + 1 - bpc_pkg::CfgWidth){1'b0}}, cfg_i.filter_time};
  assign long_ext    = {{(CmpWidth + 1 - bpc_pkg::CfgWidth){1'b0}}, cfg_i.long_time};
  assign elapsed_ext = {{(CmpWidth + 1 - bpc_pkg::ElapsedWidth){1'b0}}, elapsed_i};
  assign time_max    = {{(CmpWidth + 1 - TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
  assign sum         = time_ext + elapsed_ext;

  always_comb begin
    case (phase_q)
      PH_FILTER: begin
        if (time_ext < filter_ext) begin
          phase_d = PH_FILTER;
        end else begin
          phase_d = button_down_i ? PH_HELD : PH_IDLE;
        end
      end
      PH_HELD: begin
        if (button_down_i) begin
          phase_d = PH_HELD;
        end else begin
          phase_d = (time_ext < long_ext) ? PH_SHORT : PH_LONG;
        end
      end
      PH_SHORT: phase_d = PH_IDLE;
      PH_LONG:  phase_d = PH_IDLE;
      default:  phase_d = button_down_i ? PH_FILTER : PH_IDLE;
    endcase

    if (phase_d != phase_q) begin
      time_d = '0;
    end else if (sum > time_max) begin
      time_d = '1;
    end else begin
      time_d = sum[TIME_WIDTH-1:0];
    end

    case (phase_d)
      PH_SHORT: event_o = bpc_pkg::EV_SHORT;
      PH_LONG:  event_o = bpc_pkg::EV_LONG;
      default:  event_o = bpc_pkg::EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      time_q  <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      time_q  <= time_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/button_press_classifier_unit.sv =====
// Button press classifier top level: stream ports, input and result registers.
// Depends on bpc_pkg, bpc_cfg_regs and bpc_fsm.
//
// Each input transaction carries one button sample and the milliseconds since the
// previous sample; each yields exactly one result transaction with the press event
// (none, short or long) seen after that sample. The block takes one transaction
// per clock cycle while the output is not stalled; the sample is held in the input
// register, from which its result is written to the result register. The rate is
// set by the update of the phase register and time counter, whose logic sits
// between the input register and the result register. Configuration writes take
// effect on the next cycle and are meant to be issued while no transaction is in flight.
`default_nettype none

module button_press_classifier_unit #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bpc_pkg::IndexWidth-1:0] cfg_index_i,
  input  wire logic [bpc_pkg::CfgWidth-1:0]   cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: button_down [0], elapsed_ms [16:1], zero fill [23:17].
  input  wire logic [23:0]                    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // Fields from bit 0 up: press_event [1:0], zero fill [7:2].
  output logic      [7:0]                     m_axis_tdata
);

  bpc_pkg::cfg_t cfg;

  logic                             in_valid_q, in_valid_d;
  logic                             in_down_q;
  logic [bpc_pkg::ElapsedWidth-1:0] in_elapsed_q;
  logic                             out_valid_q, out_valid_d;
  logic [bpc_pkg::EventWidth-1:0]   out_event_q;
  logic [bpc_pkg::EventWidth-1:0]   event_d;
  logic                             accept;
  logic                             advance;

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bpc_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .button_down_i (in_down_q),
    .elapsed_i     (in_elapsed_q),
    .cfg_i         (cfg),
    .event_o       (event_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_down_q    <= s_axis_tdata[0];
      in_elapsed_q <= s_axis_tdata[bpc_pkg::ElapsedWidth:1];
    end
    if (advance) begin
      out_event_q <= event_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - bpc_pkg::EventWidth){1'b0}}, out_event_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("press event code 3 produced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("advanced item did not reach the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are full and stalled");

endmodule

`default_nettype wire

// ===== tb/button_press_classifier_unit_test.sv =====
// Self-checking testbench for button_press_classifier_unit, with a built-in predictor.
// It runs directed and random press sequences under several threshold settings.
// Depends on bpc_pkg and the button_press_classifier_unit RTL.
`timescale 1ns / 100ps

module button_press_classifier_unit_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam logic [bpc_pkg::IndexWidth-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [bpc_pkg::IndexWidth-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FILTER = 3'd1,
    PH_HELD   = 3'd2,
    PH_SHORT  = 3'd3,
    PH_LONG   = 3'd4
  } phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bpc_pkg::IndexWidth-1:0] cfg_index_i = '0;
  logic [bpc_pkg::CfgWidth-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [7:0] m_axis_tdata;

  phase_e press_phase = PH_IDLE;
  logic [15:0] phase_ms = '0;
  logic [15:0] filter_ms = bpc_pkg::FILTER_TIME_RESET;
  logic [15:0] long_ms = bpc_pkg::LONG_TIME_RESET;

  logic [1:0] pending_events[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sample_count = 0;
  int unsigned checked_count = 0;
  int unsigned short_count = 0;
  int unsigned long_count = 0;
  int unsigned setting_count = 1;
  bit idle_on = 1'b1;

  button_press_classifier_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
             pending_events.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [1:0] classify_sample(bit down, logic [15:0] elapsed);
    phase_e next_phase;
    logic [16:0] sum;
    case (press_phase)
      PH_FILTER: begin
        if (phase_ms < filter_ms) next_phase = PH_FILTER;
        else next_phase = down ? PH_HELD : PH_IDLE;
      end
      PH_HELD: begin
        if (down) next_phase = PH_HELD;
        else next_phase = (phase_ms < long_ms) ? PH_SHORT : PH_LONG;
      end
      PH_SHORT, PH_LONG: next_phase = PH_IDLE;
      default: next_phase = down ? PH_FILTER : PH_IDLE;
    endcase
    if (next_phase != press_phase) begin
      press_phase = next_phase;
      phase_ms = '0;
    end else begin
      sum = {1'b0, phase_ms} + {1'b0, elapsed};
      phase_ms = sum[16] ? 16'hFFFF : sum[15:0];
    end
    case (press_phase)
      PH_SHORT: return bpc_pkg::EV_SHORT;
      PH_LONG: return bpc_pkg::EV_LONG;
      default: return bpc_pkg::EV_NONE;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected result transaction", m_axis_tdata, '0);
      end else begin
        logic [1:0] want;
        want = pending_events.pop_front();
        checked_count++;
        if (want == bpc_pkg::EV_SHORT) short_count++;
        if (want == bpc_pkg::EV_LONG) long_count++;
        if (m_axis_tdata[1:0] !== want) begin
          report_mismatch("press_event", {6'b0, m_axis_tdata[1:0]}, {6'b0, want});
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_sample(bit down, logic [15:0] elapsed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, elapsed, down};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_events.push_back(classify_sample(down, elapsed));
    sample_count++;
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bpc_pkg::IndexWidth-1:0] index,
                           logic [bpc_pkg::CfgWidth-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == bpc_pkg::CFG_FILTER_TIME) filter_ms = value;
    else if (index == bpc_pkg::CFG_LONG_TIME) long_ms = value;
  endtask

  task automatic set_thresholds(logic [15:0] filter_value, logic [15:0] long_value);
    wait_until_drained();
    write_reg(bpc_pkg::CFG_FILTER_TIME, filter_value);
    write_reg(bpc_pkg::CFG_LONG_TIME, long_value);
    setting_count++;
  endtask

  task automatic test_default_thresholds();
    send_sample(1'b0, 16'hFFFF);
    send_sample(1'b1, 16'd7);
    send_sample(1'b0, 16'd6);
    send_sample(1'b1, 16'd4);
    send_sample(1'b1, 16'd0);
    send_sample(1'b1, 16'd499);
    send_sample(1'b0, 16'd1);
    send_sample(1'b0, 16'd0);
    send_sample(1'b1, 16'd10);
    send_sample(1'b1, 16'd10);
    send_sample(1'b1, 16'd0);
    send_sample(1'b1, 16'd500);
    send_sample(1'b0, 16'd0);
    send_sample(1'b0, 16'd0);
    send_sample(1'b1, 16'd20);
    send_sample(1'b1, 16'd20);
    send_sample(1'b0, 16'd0);
  endtask

  task automatic test_zero_thresholds();
    set_thresholds(16'd0, 16'd0);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    send_sample(1'b1, 16'd0);
    send_sample(1'b1, 16'd0);
    send_sample(1'b0, 16'd0);
    send_sample(1'b1, 16'd3);
    send_sample(1'b0, 16'd0);
  endtask

  task automatic test_time_saturation();
    set_thresholds(16'hFFFF, 16'hFFFF);
    send_sample(1'b1, 16'd0);
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b1, 16'hFFFF);
    send_sample(1'b0, 16'd0);
    send_sample(1'b0, 16'd0);
  endtask

  task automatic random_presses(int unsigned count, int unsigned max_ms);
    int unsigned target;
    int unsigned steps;
    target = sample_count + count;
    while (sample_count < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_sample(1'($urandom_range(0, 1)), 16'($urandom_range(0, max_ms)));
        end
      end else begin
        send_sample(1'b1, 16'($urandom_range(0, max_ms)));
        steps = $urandom_range(0, 4);
        repeat (steps) begin
          send_sample($urandom_range(0, 3) != 0, 16'($urandom_range(0, max_ms)));
        end
        send_sample(1'b1, 16'($urandom_range(0, max_ms)));
        steps = $urandom_range(1, 6);
        repeat (steps) send_sample(1'b1, 16'($urandom_range(0, max_ms)));
        send_sample(1'b0, 16'($urandom_range(0, max_ms)));
        repeat ($urandom_range(1, 2)) send_sample(1'b0, 16'($urandom_range(0, max_ms)));
      end
    end
  endtask

  task automatic test_random_settings();
    set_thresholds(16'($urandom_range(0, 50)), 16'($urandom_range(0, 600)));
    random_presses(100, 255);
    set_thresholds(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_presses(100, 65535);
    set_thresholds(16'd0, 16'hFFFF);
    random_presses(100, 65535);
    set_thresholds(16'hFFFF, 16'd0);
    random_presses(100, 65535);
    set_thresholds(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 16383)));
    idle_on = 1'b0;
    random_presses(100, 4095);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_thresholds();
    test_zero_thresholds();
    test_time_saturation();
    test_random_settings();
    wait_until_drained();
    $display("Sent %0d button samples under %0d threshold settings; checked %0d results.",
             sample_count, setting_count, checked_count);
    $display("Results included %0d short and %0d long press events.", short_count,
             long_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
